[sv/prst_pkg.sv]
package prst_pkg;

	localparam int CORDIC_STAGES = 18;

	localparam int XW = 31;
	localparam int ZW = 32;
	localparam int OW = 42;
	localparam int TW = 43;
	localparam int FRAC_ROT = 28;
	localparam int FRAC_SCALE = 16;

	localparam logic signed [XW-1:0] INV_GAIN = XW'(163008218);

	localparam int Q_OFS_FULL = 5826;
	localparam logic [20:0] ANG_OFS = 21'(90 * Q_OFS_FULL);
	localparam logic [9:0] Q_OFS = 10'(Q_OFS_FULL % 1024);
	localparam logic [21:0] RECIP_90 = 22'd2982617;
	localparam int RECIP_SH = 28;
	localparam int QW = 15;

	typedef enum logic [1:0] {
		CMD_MOVE   = 2'd0,
		CMD_ROTATE = 2'd1,
		CMD_SCALE  = 2'd2,
		CMD_PASS   = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t               cmd;
		logic signed [31:0] vertex_x;
		logic signed [31:0] vertex_y;
		logic signed [31:0] centre_x;
		logic signed [31:0] centre_y;
		logic signed [31:0] target_x;
		logic signed [31:0] target_y;
		logic signed [19:0] angle;
		logic signed [23:0] scale_factor;
	} pt_in_t;

	typedef struct packed {
		cmd_t               cmd;
		logic               flip;
		logic signed [33:0] base_x;
		logic signed [33:0] base_y;
		logic signed [32:0] dx;
		logic signed [32:0] dy;
		logic signed [23:0] sf;
	} pl_t;

	typedef struct packed {
		logic signed [31:0] result_x;
		logic signed [31:0] result_y;
		logic               overflow;
	} pt_out_t;

	localparam logic signed [ZW-1:0] ATAN_TAB [32] = '{
		32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
		32'sd42667331, 32'sd21354465, 32'sd10679838, 32'sd5340245,
		32'sd2670163, 32'sd1335087, 32'sd667544, 32'sd333772,
		32'sd166886, 32'sd83443, 32'sd41722, 32'sd20861,
		32'sd10430, 32'sd5215, 32'sd2608, 32'sd1304,
		32'sd652, 32'sd326, 32'sd163, 32'sd81,
		32'sd41, 32'sd20, 32'sd10, 32'sd5,
		32'sd3, 32'sd1, 32'sd1, 32'sd0
	};

	function automatic logic signed [ZW-1:0] atan_at(input int i);
		logic [4:0] idx;
		idx = i[4:0];
		if (i < 32) begin
			return ATAN_TAB[idx];
		end
		return '0;
	endfunction

	typedef logic [89:0][22:0] theta_tab_t;

	function automatic theta_tab_t gen_theta_tab();
		theta_tab_t t;
		logic [63:0] n;
		for (int i = 0; i < 90; i++) begin
			n = (64'(i) * 64'd4194304 + 64'd45) / 64'd90;
			t[i] = n[22:0];
		end
		return t;
	endfunction

	localparam theta_tab_t THETA_TAB = gen_theta_tab();

endpackage

[sv/prst_front.sv]
module prst_front import prst_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  pt_in_t               in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [ZW-1:0] out_z,
	output pl_t                  out_pl
);

	logic v_s1, v_s2, v_s3;
	logic en1, en2, en3;
	pl_t pl_d, pl_f, pl_s1, pl_s2, pl_s3;
	logic [20:0] au_s1, au_s2;
	logic [QW-1:0] q_s2;
	logic signed [ZW-1:0] z_s3;
	logic signed [33:0] vx_e, vy_e, cx_e, cy_e, tx_e, ty_e;
	logic [42:0] prod;
	logic [20:0] rem;
	logic [6:0] m;
	logic [9:0] th_hi;
	logic [31:0] theta;

	assign en3 = !v_s3 || out_ready;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;

	always_comb begin
		vx_e = 34'(in_data.vertex_x);
		vy_e = 34'(in_data.vertex_y);
		cx_e = 34'(in_data.centre_x);
		cy_e = 34'(in_data.centre_y);
		tx_e = 34'(in_data.target_x);
		ty_e = 34'(in_data.target_y);
		pl_d.cmd = in_data.cmd;
		pl_d.flip = 1'b0;
		pl_d.dx = 33'(in_data.vertex_x) - 33'(in_data.centre_x);
		pl_d.dy = 33'(in_data.vertex_y) - 33'(in_data.centre_y);
		pl_d.sf = in_data.scale_factor;
		case (in_data.cmd)
			CMD_MOVE: begin
				pl_d.base_x = vx_e + tx_e - cx_e;
				pl_d.base_y = vy_e + ty_e - cy_e;
			end
			CMD_ROTATE, CMD_SCALE: begin
				pl_d.base_x = cx_e;
				pl_d.base_y = cy_e;
			end
			default: begin
				pl_d.base_x = vx_e;
				pl_d.base_y = vy_e;
			end
		endcase
	end

	assign prod = 43'(au_s1) * 43'(RECIP_90);
	assign rem = au_s2 - 21'(q_s2) * 21'd90;
	assign m = rem[6:0];
	assign th_hi = q_s2[9:0] - Q_OFS;
	assign theta = {th_hi, 22'd0} + 32'(THETA_TAB[m]);

	always_comb begin
		pl_f = pl_s2;
		pl_f.flip = theta[31] ^ theta[30];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			pl_s1 <= pl_d;
			au_s1 <= 21'(in_data.angle) + ANG_OFS;
		end
		if (en2) begin
			pl_s2 <= pl_s1;
			au_s2 <= au_s1;
			q_s2 <= prod[RECIP_SH +: QW];
		end
		if (en3) begin
			pl_s3 <= pl_f;
			z_s3 <= {theta[30], theta[30:0]};
		end
	end

	assign out_valid = v_s3;
	assign out_z = z_s3;
	assign out_pl = pl_s3;

endmodule

[sv/prst_cordic.sv]
module prst_cordic import prst_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [ZW-1:0] in_z,
	input  pl_t                  in_pl,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [XW-1:0] out_x,
	output logic signed [XW-1:0] out_y,
	output pl_t                  out_pl
);

	logic [CORDIC_STAGES:0] en;
	logic [CORDIC_STAGES-1:0] v_s;
	logic signed [XW-1:0] x_s [CORDIC_STAGES];
	logic signed [XW-1:0] y_s [CORDIC_STAGES];
	logic signed [ZW-1:0] z_s [CORDIC_STAGES];
	pl_t pl_s [CORDIC_STAGES];

	assign en[CORDIC_STAGES] = out_ready;
	assign in_ready = en[0];

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
		localparam logic signed [ZW-1:0] ANG = atan_at(i);
		logic signed [XW-1:0] xi, yi, xsh, ysh;
		logic signed [ZW-1:0] zi;
		pl_t pli;
		logic vi;

		if (i == 0) begin : g_head
			assign xi = INV_GAIN;
			assign yi = '0;
			assign zi = in_z;
			assign pli = in_pl;
			assign vi = in_valid;
		end else begin : g_link
			assign xi = x_s[i-1];
			assign yi = y_s[i-1];
			assign zi = z_s[i-1];
			assign pli = pl_s[i-1];
			assign vi = v_s[i-1];
		end

		assign en[i] = !v_s[i] || en[i+1];
		assign xsh = xi >>> i;
		assign ysh = yi >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en[i]) begin
				v_s[i] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en[i]) begin
				pl_s[i] <= pli;
				if (zi >= 0) begin
					x_s[i] <= xi - ysh;
					y_s[i] <= yi + xsh;
					z_s[i] <= zi - ANG;
				end else begin
					x_s[i] <= xi + ysh;
					y_s[i] <= yi - xsh;
					z_s[i] <= zi + ANG;
				end
			end
		end
	end

	assign out_valid = v_s[CORDIC_STAGES-1];
	assign out_x = x_s[CORDIC_STAGES-1];
	assign out_y = y_s[CORDIC_STAGES-1];
	assign out_pl = pl_s[CORDIC_STAGES-1];

endmodule

[sv/prst_apply.sv]
module prst_apply import prst_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [XW-1:0] in_x,
	input  logic signed [XW-1:0] in_y,
	input  pl_t                  in_pl,
	output logic                 out_valid,
	input  logic                 out_ready,
	output pt_out_t              out_data
);

	localparam logic signed [64:0] RND_ROT = 65'sd1 <<< (FRAC_ROT - 1);
	localparam logic signed [64:0] RND_SCALE = 65'sd1 <<< (FRAC_SCALE - 1);

	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;
	pl_t pl_s1, pl_s2, pl_s3;
	logic signed [XW-1:0] kc_s1, ks_s1, kc_d, ks_d, c_d, s_d;
	logic signed [63:0] px1_s2, px2_s2, py1_s2, py2_s2;
	logic signed [64:0] sum_x, sum_y, rx_sh, ry_sh;
	logic signed [OW-1:0] offx_s3, offy_s3, offx_d, offy_d;
	logic signed [TW-1:0] tot_x, tot_y;
	logic [32:0] sat_x, sat_y;
	pt_out_t out_s4;

	function automatic logic [32:0] sat32(input logic signed [TW-1:0] v);
		logic same;
		same = (&v[TW-1:31]) | ~(|v[TW-1:31]);
		if (same) begin
			return {1'b0, v[31:0]};
		end else if (v[TW-1]) begin
			return {1'b1, 1'b1, 31'd0};
		end
		return {1'b1, 1'b0, {31{1'b1}}};
	endfunction

	assign en4 = !v_s4 || out_ready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;

	always_comb begin
		c_d = in_pl.flip ? -in_x : in_x;
		s_d = in_pl.flip ? -in_y : in_y;
		case (in_pl.cmd)
			CMD_ROTATE: begin
				kc_d = c_d;
				ks_d = s_d;
			end
			CMD_SCALE: begin
				kc_d = XW'(in_pl.sf);
				ks_d = '0;
			end
			default: begin
				kc_d = '0;
				ks_d = '0;
			end
		endcase
	end

	always_comb begin
		sum_x = 65'(px1_s2) - 65'(px2_s2);
		sum_y = 65'(py1_s2) + 65'(py2_s2);
		case (pl_s2.cmd)
			CMD_ROTATE: begin
				rx_sh = (sum_x + RND_ROT) >>> FRAC_ROT;
				ry_sh = (sum_y + RND_ROT) >>> FRAC_ROT;
			end
			CMD_SCALE: begin
				rx_sh = (sum_x + RND_SCALE) >>> FRAC_SCALE;
				ry_sh = (sum_y + RND_SCALE) >>> FRAC_SCALE;
			end
			default: begin
				rx_sh = '0;
				ry_sh = '0;
			end
		endcase
		offx_d = rx_sh[OW-1:0];
		offy_d = ry_sh[OW-1:0];
	end

	assign tot_x = TW'(pl_s3.base_x) + TW'(offx_s3);
	assign tot_y = TW'(pl_s3.base_y) + TW'(offy_s3);
	assign sat_x = sat32(tot_x);
	assign sat_y = sat32(tot_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			pl_s1 <= in_pl;
			kc_s1 <= kc_d;
			ks_s1 <= ks_d;
		end
		if (en2) begin
			pl_s2 <= pl_s1;
			px1_s2 <= 64'(pl_s1.dx) * 64'(kc_s1);
			px2_s2 <= 64'(pl_s1.dy) * 64'(ks_s1);
			py1_s2 <= 64'(pl_s1.dx) * 64'(ks_s1);
			py2_s2 <= 64'(pl_s1.dy) * 64'(kc_s1);
		end
		if (en3) begin
			pl_s3 <= pl_s2;
			offx_s3 <= offx_d;
			offy_s3 <= offy_d;
		end
		if (en4) begin
			out_s4.result_x <= sat_x[31:0];
			out_s4.result_y <= sat_y[31:0];
			out_s4.overflow <= sat_x[32] | sat_y[32];
		end
	end

	assign out_valid = v_s4;
	assign out_data = out_s4;

endmodule

[sv/point_rotate_scale_translate_top.sv]
// Moves, rotates or scales one 2-D vertex per transaction, or passes it through.
// Input stream (s_axis): tuser carries the command (move, rotate, scale, pass),
// tdata carries vertex, centre, target, angle and scale factor, all signed
// fixed point. Output stream (m_axis): tdata carries the transformed vertex,
// tuser carries the saturation flag.
// Pipeline: registered angle reduction stages in prst_front, one CORDIC stage
// per iteration (18 CORDIC stages by default), then registered multiply, round
// and saturate stages in prst_apply.
// Throughput: one transaction per cycle while m_axis_tready stays high; each stage holds one item and a
// valid bit, and an empty stage takes a new item even while a later stage
// is stalled.
// Reset clears every valid bit; the pipeline comes up empty with s_axis_tready
// high. When the receiver drops m_axis_tready, the result holds on m_axis and
// the stages fill up behind it; s_axis_tready falls once every stage holds an
// item, and nothing is lost or repeated.
module point_rotate_scale_translate_top import prst_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// vertex_x, vertex_y, centre_x, centre_y, target_x, target_y, angle, scale_factor
	input  logic [239:0] s_axis_tdata,
	// cmd
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// result_x, result_y
	output logic [63:0]  m_axis_tdata,
	// overflow
	output logic         m_axis_tuser
);

	pt_in_t in_data;
	logic f_valid, f_ready;
	logic signed [ZW-1:0] f_z;
	pl_t f_pl;
	logic c_valid, c_ready;
	logic signed [XW-1:0] c_x, c_y;
	pl_t c_pl;
	pt_out_t out_data;

	always_comb begin
		in_data.cmd = cmd_t'(s_axis_tuser);
		in_data.vertex_x = s_axis_tdata[31:0];
		in_data.vertex_y = s_axis_tdata[63:32];
		in_data.centre_x = s_axis_tdata[95:64];
		in_data.centre_y = s_axis_tdata[127:96];
		in_data.target_x = s_axis_tdata[159:128];
		in_data.target_y = s_axis_tdata[191:160];
		in_data.angle = s_axis_tdata[211:192];
		in_data.scale_factor = s_axis_tdata[235:212];
	end

	prst_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (in_data),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.out_z     (f_z),
		.out_pl    (f_pl)
	);

	prst_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_z      (f_z),
		.in_pl     (f_pl),
		.out_valid (c_valid),
		.out_ready (c_ready),
		.out_x     (c_x),
		.out_y     (c_y),
		.out_pl    (c_pl)
	);

	prst_apply u_apply (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (c_valid),
		.in_ready  (c_ready),
		.in_x      (c_x),
		.in_y      (c_y),
		.in_pl     (c_pl),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (out_data)
	);

	assign m_axis_tdata = {out_data.result_y, out_data.result_x};
	assign m_axis_tuser = out_data.overflow;

endmodule
